// ===== rtl/core/whf_pkg.sv =====
// ============================================================================
// Weighted histogram fill: shared package
// Field widths, stream packing, register indexes, operation codes and the
// layout of one histogram memory word.
// ============================================================================
package whf_pkg;

  // Default number of bins held in the histogram memory.
  localparam int unsigned MAX_BINS_DEF = 1024;

  // Field widths.
  localparam int unsigned MODE_W      = 2;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned WEIGHT_W    = 24;
  localparam int unsigned BIN_OUT_W   = 10;
  localparam int unsigned SUM_W       = 48;
  localparam int unsigned SQ_W        = 63;
  localparam int unsigned BIN_WIDTH_W = 31;
  localparam int unsigned BIN_COUNT_W = 11;
  localparam int unsigned SQ_PROD_W   = 2 * WEIGHT_W;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 176;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  // Reset values of the configuration registers.
  localparam logic [VALUE_W-1:0]     X_LOW_RST     = 32'd0;
  localparam logic [VALUE_W-1:0]     X_HIGH_RST    = 32'd67108864;
  localparam logic [BIN_WIDTH_W-1:0] BIN_WIDTH_RST = 31'd65536;
  localparam logic [BIN_COUNT_W-1:0] BIN_COUNT_RST = 11'd1024;

  // Saturation limits of the weight accumulators.
  localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_X_LOW     = 2'd0,
    REG_X_HIGH    = 2'd1,
    REG_BIN_WIDTH = 2'd2,
    REG_BIN_COUNT = 2'd3
  } whf_reg_e;

  // Operation carried by each input beat.
  typedef enum logic [MODE_W-1:0] {
    MODE_FILL  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NOP   = 2'd3
  } whf_mode_e;

  // One histogram memory word: weight sum and squared-weight sum of a bin.
  typedef struct packed {
    logic [SQ_W-1:0]         sq;
    logic signed [SUM_W-1:0] sum;
  } whf_entry_t;

endpackage

// ===== rtl/core/weighted_histogram_fill.sv =====
// ============================================================================
// Weighted histogram fill
// Weighted one-dimensional histogram with per-bin weight sums and squared
// weight sums, a running entry total, bin readback and clear.
// ============================================================================
//
// Channel   Direction  Beat contents (lowest bits first)
// -------   ---------  ------------------------------------------------------
// s_axis    in         tuser: mode; tdata: sample_value, sample_weight,
//                      read_bin
// m_axis    out        tdata: landed, bin_number, bin_sum, bin_sum_squares,
//                      entry_total, saturated
// cfg       in         cfg_we_i, cfg_idx_i, cfg_wdata_i; write only
//
// A fill in range goes through the check, the 32 steps of the radix-2
// divider, the bin read and the update; a fill out of range goes straight
// to the result. A read skips the divider; a clear and the pass after reset
// walk all MAX_BINS bin memory entries one a cycle, with the input not ready.
// One item is in work at a time; the result register lets the next item be
// accepted while a result beat is still waiting on m_axis_tready.
// ============================================================================
module weighted_histogram_fill #(
  parameter int unsigned MAX_BINS = whf_pkg::MAX_BINS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [31:0] sample_value, [55:32] sample_weight, [65:56] read_bin
  input  logic [whf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // [1:0] mode
  input  logic [whf_pkg::MODE_W-1:0]         s_axis_tuser,
  // Result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [0] landed, [10:1] bin_number, [58:11] bin_sum, [121:59] bin_sum_squares,
  // [169:122] entry_total, [170] saturated
  output logic [whf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // Configuration writes
  input  logic                               cfg_we_i,
  input  logic [whf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [whf_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  localparam int unsigned BIN_W = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_MEMRD,
    ST_UPD,
    ST_RESULT
  } state_e;

  // Configuration registers.
  logic signed [whf_pkg::VALUE_W-1:0]   x_low_q;
  logic signed [whf_pkg::VALUE_W-1:0]   x_high_q;
  logic [whf_pkg::BIN_WIDTH_W-1:0]      bin_width_q;
  logic [whf_pkg::BIN_COUNT_W-1:0]      bin_count_q;

  // Sequencer and item registers.
  state_e                               state_q;
  whf_pkg::whf_mode_e                   mode_q;
  logic signed [whf_pkg::VALUE_W-1:0]   value_q;
  logic signed [whf_pkg::WEIGHT_W-1:0]  weight_q;
  logic [whf_pkg::BIN_OUT_W-1:0]        read_bin_q;
  logic                                 clr_item_q;
  logic [BIN_W-1:0]                     clr_addr_q;
  logic [BIN_W-1:0]                     bin_q;
  logic [whf_pkg::SQ_PROD_W-1:0]        aw2_q;
  logic signed [whf_pkg::SUM_W-1:0]     total_q;

  // Result being assembled and the output register.
  logic                                 res_landed_q;
  logic [whf_pkg::BIN_OUT_W-1:0]        res_bin_q;
  logic [whf_pkg::SUM_W-1:0]            res_sum_q;
  logic [whf_pkg::SQ_W-1:0]             res_sq_q;
  logic                                 res_sat_q;
  logic                                 out_valid_q;
  logic [whf_pkg::OUT_TDATA_W-1:0]      out_data_q;

  // Bin memory.
  whf_pkg::whf_entry_t                  bins_mem [MAX_BINS];
  whf_pkg::whf_entry_t                  rd_data_q;
  whf_pkg::whf_entry_t                  wr_data;
  logic [BIN_W-1:0]                     wr_addr;
  logic                                 wr_en;
  logic                                 rd_en;

  // Datapath.
  logic [BIN_W-1:0]                     last_bin;
  logic                                 in_range;
  logic [whf_pkg::VALUE_W-1:0]          offset;
  logic [whf_pkg::WEIGHT_W-1:0]         abs_w;
  logic                                 read_ok;
  logic [BIN_W-1:0]                     clamped_bin;
  logic signed [whf_pkg::SUM_W:0]       tot_sum;
  logic                                 tot_sat;
  logic [whf_pkg::SUM_W-1:0]            tot_new;
  logic signed [whf_pkg::SUM_W:0]       bin_sum;
  logic                                 bin_sat;
  logic [whf_pkg::SUM_W-1:0]            bin_new;
  logic [whf_pkg::SQ_W:0]               sq_sum;
  logic                                 sq_sat;
  logic [whf_pkg::SQ_W-1:0]             sq_new;
  logic                                 in_beat;
  logic                                 out_free;

  // Divider.
  logic                                 div_start;
  logic                                 div_busy;
  logic                                 div_done;
  logic [whf_pkg::VALUE_W-1:0]          div_quo;

  whf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (offset),
    .divisor_i  (bin_width_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_low_q     <= whf_pkg::X_LOW_RST;
      x_high_q    <= whf_pkg::X_HIGH_RST;
      bin_width_q <= whf_pkg::BIN_WIDTH_RST;
      bin_count_q <= whf_pkg::BIN_COUNT_RST;
    end else if (cfg_we_i) begin
      case (whf_pkg::whf_reg_e'(cfg_idx_i))
        whf_pkg::REG_X_LOW:     x_low_q     <= cfg_wdata_i;
        whf_pkg::REG_X_HIGH:    x_high_q    <= cfg_wdata_i;
        whf_pkg::REG_BIN_WIDTH: bin_width_q <= cfg_wdata_i[whf_pkg::BIN_WIDTH_W-1:0];
        whf_pkg::REG_BIN_COUNT: bin_count_q <= cfg_wdata_i[whf_pkg::BIN_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Last bin in use: a count of zero acts as one, a count above the memory
  // depth acts as the depth.
  always_comb begin
    if (bin_count_q == '0) begin
      last_bin = '0;
    end else if (32'(bin_count_q) >= MAX_BINS) begin
      last_bin = BIN_W'(MAX_BINS - 1);
    end else begin
      last_bin = BIN_W'(bin_count_q - 1'b1);
    end
  end

  // Range check, divider operand and weight magnitude.
  always_comb begin
    in_range = (value_q < x_high_q) && (value_q >= x_low_q);
    offset   = value_q - x_low_q;
    abs_w    = weight_q[whf_pkg::WEIGHT_W-1] ? whf_pkg::WEIGHT_W'(-weight_q)
                                             : whf_pkg::WEIGHT_W'(weight_q);
    read_ok  = (32'(read_bin_q) <= 32'(last_bin));
    clamped_bin = (div_quo > 32'(last_bin)) ? last_bin : div_quo[BIN_W-1:0];
  end

  // Saturating accumulators.
  always_comb begin
    tot_sum = (whf_pkg::SUM_W+1)'(total_q) + (whf_pkg::SUM_W+1)'(weight_q);
    tot_sat = tot_sum[whf_pkg::SUM_W] ^ tot_sum[whf_pkg::SUM_W-1];
    tot_new = tot_sat ? (tot_sum[whf_pkg::SUM_W] ? whf_pkg::SUM_MIN : whf_pkg::SUM_MAX)
                      : tot_sum[whf_pkg::SUM_W-1:0];

    bin_sum = (whf_pkg::SUM_W+1)'(rd_data_q.sum) + (whf_pkg::SUM_W+1)'(weight_q);
    bin_sat = bin_sum[whf_pkg::SUM_W] ^ bin_sum[whf_pkg::SUM_W-1];
    bin_new = bin_sat ? (bin_sum[whf_pkg::SUM_W] ? whf_pkg::SUM_MIN : whf_pkg::SUM_MAX)
                      : bin_sum[whf_pkg::SUM_W-1:0];

    sq_sum = (whf_pkg::SQ_W+1)'(rd_data_q.sq) + (whf_pkg::SQ_W+1)'(aw2_q);
    sq_sat = sq_sum[whf_pkg::SQ_W];
    sq_new = sq_sat ? {whf_pkg::SQ_W{1'b1}} : sq_sum[whf_pkg::SQ_W-1:0];
  end

  // Handshake and sequencer strobes.
  assign in_beat   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign div_start = (state_q == ST_CHECK) && (mode_q == whf_pkg::MODE_FILL) && in_range;
  assign rd_en     = (state_q == ST_MEMRD);

  // Memory write port: the clearing pass or the update of a filled bin.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = bin_q;
    wr_data = '0;
    if (state_q == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_addr_q;
    end else if ((state_q == ST_UPD) && (mode_q == whf_pkg::MODE_FILL)) begin
      wr_en       = 1'b1;
      wr_data.sum = bin_new;
      wr_data.sq  = sq_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      bins_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= bins_mem[bin_q];
    end
  end

  // Sequencer with the result and output registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      mode_q       <= whf_pkg::MODE_NOP;
      value_q      <= '0;
      weight_q     <= '0;
      read_bin_q   <= '0;
      clr_item_q   <= 1'b0;
      clr_addr_q   <= '0;
      bin_q        <= '0;
      aw2_q        <= '0;
      total_q      <= '0;
      res_landed_q <= 1'b0;
      res_bin_q    <= '0;
      res_sum_q    <= '0;
      res_sq_q     <= '0;
      res_sat_q    <= 1'b0;
      out_valid_q  <= 1'b0;
      out_data_q   <= '0;
    end else begin
      // Output register: loaded from the result state, emptied by a taken beat.
      if ((state_q == ST_RESULT) && out_free) begin
        out_valid_q <= 1'b1;
        out_data_q  <= {5'b0, res_sat_q, total_q, res_sq_q, res_sum_q,
                        res_bin_q, res_landed_q};
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        // Zero the bin memory one entry a cycle.
        ST_CLEAR: begin
          total_q <= '0;
          if (clr_addr_q == BIN_W'(MAX_BINS - 1)) begin
            clr_addr_q <= '0;
            clr_item_q <= 1'b0;
            if (clr_item_q) begin
              res_landed_q <= 1'b0;
              res_bin_q    <= '0;
              res_sum_q    <= '0;
              res_sq_q     <= '0;
              res_sat_q    <= 1'b0;
              state_q      <= ST_RESULT;
            end else begin
              state_q <= ST_IDLE;
            end
          end else begin
            clr_addr_q <= clr_addr_q + 1'b1;
          end
        end
        // Take one beat from the input.
        ST_IDLE: begin
          if (in_beat) begin
            mode_q     <= whf_pkg::whf_mode_e'(s_axis_tuser);
            value_q    <= s_axis_tdata[31:0];
            weight_q   <= s_axis_tdata[55:32];
            read_bin_q <= s_axis_tdata[65:56];
            state_q    <= ST_CHECK;
          end
        end
        // Decode the operation; a fill squares its weight meanwhile.
        ST_CHECK: begin
          aw2_q        <= abs_w * abs_w;
          res_landed_q <= 1'b0;
          res_sum_q    <= '0;
          res_sq_q     <= '0;
          case (mode_q)
            whf_pkg::MODE_FILL: begin
              res_bin_q <= '0;
              if (in_range) begin
                res_sat_q <= 1'b0;
                state_q   <= ST_DIV;
              end else begin
                total_q   <= tot_new;
                res_sat_q <= tot_sat;
                state_q   <= ST_RESULT;
              end
            end
            whf_pkg::MODE_READ: begin
              res_bin_q <= read_bin_q;
              res_sat_q <= 1'b0;
              if (read_ok) begin
                bin_q   <= BIN_W'(read_bin_q);
                state_q <= ST_MEMRD;
              end else begin
                state_q <= ST_RESULT;
              end
            end
            whf_pkg::MODE_CLEAR: begin
              res_bin_q  <= '0;
              res_sat_q  <= 1'b0;
              clr_item_q <= 1'b1;
              clr_addr_q <= '0;
              state_q    <= ST_CLEAR;
            end
            default: begin
              res_bin_q <= '0;
              res_sat_q <= 1'b0;
              state_q   <= ST_RESULT;
            end
          endcase
        end
        // Wait for the quotient and clamp it to the last bin in use.
        ST_DIV: begin
          if (div_done) begin
            bin_q   <= clamped_bin;
            state_q <= ST_MEMRD;
          end
        end
        // Memory read of the bin is under way.
        ST_MEMRD: begin
          state_q <= ST_UPD;
        end
        // Accumulate into the bin, or pass the read data on.
        ST_UPD: begin
          if (mode_q == whf_pkg::MODE_FILL) begin
            total_q      <= tot_new;
            res_landed_q <= 1'b1;
            res_bin_q    <= whf_pkg::BIN_OUT_W'(bin_q);
            res_sum_q    <= bin_new;
            res_sq_q     <= sq_new;
            res_sat_q    <= tot_sat | bin_sat | sq_sat;
          end else begin
            res_sum_q <= rd_data_q.sum;
            res_sq_q  <= rd_data_q.sq;
          end
          state_q <= ST_RESULT;
        end
        // Hand the result to the output register once it is free.
        ST_RESULT: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  // The input is never taken while the divider still works on an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !div_busy)
    else $error("input ready while divider busy");

  // A quotient only arrives while the sequencer waits for it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide state");

  // Every memory read stays within the bins in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (32'(bin_q) <= 32'(last_bin)))
    else $error("bin index beyond the last bin in use");

  // The bin memory is written only by the clearing pass or a fill update.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> ((state_q == ST_CLEAR) ||
               ((state_q == ST_UPD) && (mode_q == whf_pkg::MODE_FILL))))
    else $error("unexpected bin memory write");

  // A new result beat is only raised from the result state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == ST_RESULT))
    else $error("result beat raised outside the result state");
`endif

endmodule

// ===== rtl/core/whf_div.sv =====
// ============================================================================
// Weighted histogram fill: radix-2 divider
// Restoring divider that produces one quotient bit a cycle. A zero divisor
// gives an all-ones quotient.
// ============================================================================
module whf_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic [whf_pkg::VALUE_W-1:0]        dividend_i,
  input  logic [whf_pkg::BIN_WIDTH_W-1:0]    divisor_i,
  output logic                               busy_o,
  output logic                               done_o,
  output logic [whf_pkg::VALUE_W-1:0]        quotient_o
);

  localparam int unsigned CNT_W = $clog2(whf_pkg::VALUE_W);

  logic                              busy_q;
  logic                              done_q;
  logic [CNT_W-1:0]                  cnt_q;
  logic [whf_pkg::BIN_WIDTH_W-1:0]   rem_q;
  logic [whf_pkg::BIN_WIDTH_W-1:0]   div_q;
  logic [whf_pkg::VALUE_W-1:0]       quo_q;

  logic [whf_pkg::BIN_WIDTH_W:0]     trial;
  logic [whf_pkg::BIN_WIDTH_W:0]     diff;
  logic                              fits;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  always_comb begin
    trial = {rem_q, quo_q[whf_pkg::VALUE_W-1]};
    diff  = trial - {1'b0, div_q};
    fits  = (trial >= {1'b0, div_q});
  end

  // Iteration state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      div_q  <= '0;
      quo_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rem_q  <= '0;
        div_q  <= divisor_i;
        quo_q  <= dividend_i;
      end else if (busy_q) begin
        rem_q <= fits ? diff[whf_pkg::BIN_WIDTH_W-1:0] : trial[whf_pkg::BIN_WIDTH_W-1:0];
        quo_q <= {quo_q[whf_pkg::VALUE_W-2:0], fits};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(whf_pkg::VALUE_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule
